>>> rtl/failed_login_source_blocklist_assert.svh
// Assertion macros shared by the failed-login source blocklist RTL.
// Each macro expects a signal named clock and a signal named reset in the module that uses it.
`ifndef FAILED_LOGIN_SOURCE_BLOCKLIST_ASSERT_SVH
`define FAILED_LOGIN_SOURCE_BLOCKLIST_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FLS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define FLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fls_pkg.sv
// Shared types and constants for the failed-login source blocklist.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fls_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_SECONDS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTEMPT_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXEMPT_ADDR_A = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXEMPT_ADDR_B = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXEMPT_ENABLE = 3'd4;

   // Field widths
   localparam int CSR_DATA_BITS = 32;
   localparam int ADDR_BITS     = 32;
   localparam int TIME_BITS     = 32;
   localparam int LIMIT_BITS    = 16;
   localparam int OUT_CNT_BITS  = 16;
   localparam int EXEMPT_BITS   = 2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SELECT,
      ST_READ,
      ST_CALC,
      ST_UPDATE
   } fls_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the request item
      logic match;     // parallel tag compare
      logic select;    // priority pick of hit or free entry
      logic read;      // read entry data from RAM
      logic calc;      // elapsed time and base count
      logic update;    // write table and load response
      logic record;    // failure is recorded into the selected entry
      logic check;     // check hit a tracked entry
   } fls_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic cmd_fail;
      logic exempt;
      logic hit;
      logic free_any;
   } fls_status_type;

endpackage

>>> rtl/failed_login_source_blocklist.sv
// Top level of the failed-login source blocklist: controller plus datapath.
// Depends on fls_pkg, fls_ctrl and fls_datapath.
// The result strobe rsp_valid is registered after the update step.
// One item at a time: an item walks the steps (compare, select, RAM read, time and count calc,
// update) with busy high, and no new item is taken until it is done.
// Reset: valid bits, config registers and controller clear at once; no clearing pass.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps

module failed_login_source_blocklist #(
   parameter int TABLE_ENTRIES = 16,
   parameter int COUNT_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_en,
   input  logic [fls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fls_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   // request item
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [fls_pkg::ADDR_BITS-1:0]      req_src_addr,
   input  logic [fls_pkg::TIME_BITS-1:0]      req_now_seconds,
   // response item
   output logic                               rsp_valid,
   output logic                               rsp_blocked,
   output logic                               rsp_exempt_hit,
   output logic                               rsp_released,
   output logic [fls_pkg::TIME_BITS-1:0]      rsp_remaining_seconds,
   output logic [fls_pkg::OUT_CNT_BITS-1:0]   rsp_attempt_count,
   output logic                               rsp_table_full
);

   import fls_pkg::*;

   fls_cmd_type    cmd;
   fls_status_type status;

   // Step sequencer
   fls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Table and arithmetic
   fls_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_cmd               (req_cmd),
      .req_src_addr          (req_src_addr),
      .req_now_seconds       (req_now_seconds),
      .cmd                   (cmd),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_blocked           (rsp_blocked),
      .rsp_exempt_hit        (rsp_exempt_hit),
      .rsp_released          (rsp_released),
      .rsp_remaining_seconds (rsp_remaining_seconds),
      .rsp_attempt_count     (rsp_attempt_count),
      .rsp_table_full        (rsp_table_full)
   );

endmodule

>>> rtl/fls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fls_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fls_ctrl.sv
// Controller state machine for the failed-login source blocklist.
// Depends on fls_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "failed_login_source_blocklist_assert.svh"

module fls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  fls_pkg::fls_status_type status,
   output fls_pkg::fls_cmd_type    cmd
);

   import fls_pkg::*;

   fls_state_type state_ff;
   fls_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands: one item walks the steps in order
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.record = status.cmd_fail && !status.exempt &&
                         (status.hit || status.free_any);
            cmd.check  = !status.cmd_fail && status.hit;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // An accepted item keeps the block busy
   `FLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   // The update step ends the item
   `FLS_ASSERT_NEXT(a_update_ends, cmd.update, !busy, "block still busy after update")
   // At most one step command per cycle
   `FLS_ASSERT_NOW(a_one_step, 1'b1,
      $onehot0({cmd.capture, cmd.match, cmd.select, cmd.read, cmd.calc, cmd.update}),
      "more than one step command active")
   // Record and check only come with the update step
   `FLS_ASSERT_NOW(a_record_check, cmd.record || cmd.check,
      cmd.update && !(cmd.record && cmd.check), "record or check outside update")

endmodule

>>> rtl/fls_datapath.sv
// Datapath of the failed-login source blocklist: config registers, tag table, entry RAM,
// response registers. Depends on fls_pkg, fls_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "failed_login_source_blocklist_assert.svh"

module fls_datapath #(
   parameter int TABLE_ENTRIES = 16,
   parameter int COUNT_BITS    = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // configuration
   input  logic                                       csr_write_en,
   input  logic [fls_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [fls_pkg::CSR_DATA_BITS-1:0]          csr_wdata,
   // request item
   input  logic                                       req_cmd,
   input  logic [fls_pkg::ADDR_BITS-1:0]              req_src_addr,
   input  logic [fls_pkg::TIME_BITS-1:0]              req_now_seconds,
   // control
   input  fls_pkg::fls_cmd_type                       cmd,
   output fls_pkg::fls_status_type                    status,
   // response item
   output logic                                       rsp_valid,
   output logic                                       rsp_blocked,
   output logic                                       rsp_exempt_hit,
   output logic                                       rsp_released,
   output logic [fls_pkg::TIME_BITS-1:0]              rsp_remaining_seconds,
   output logic [fls_pkg::OUT_CNT_BITS-1:0]           rsp_attempt_count,
   output logic                                       rsp_table_full
);

   import fls_pkg::*;

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = COUNT_BITS + TIME_BITS;

   // Configuration registers
   logic [TIME_BITS-1:0]   block_seconds_ff;
   logic [LIMIT_BITS-1:0]  attempt_limit_ff;
   logic [ADDR_BITS-1:0]   exempt_addr_a_ff;
   logic [ADDR_BITS-1:0]   exempt_addr_b_ff;
   logic [EXEMPT_BITS-1:0] exempt_enable_ff;

   // Captured item
   logic                   cmd_ff;
   logic [ADDR_BITS-1:0]   key_ff;
   logic [TIME_BITS-1:0]   now_ff;

   // Tag table
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [ADDR_BITS-1:0]     slot_addr_ff [TABLE_ENTRIES];

   // Compare and select results
   logic [TABLE_ENTRIES-1:0] match_ff, match_in;
   logic [TABLE_ENTRIES-1:0] free_ff, free_in;
   logic                     exempt_ff, exempt_in;
   logic                     hit_ff, hit_in;
   logic                     free_any_ff, free_any_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [IDX_W-1:0]         hit_idx;
   logic [IDX_W-1:0]         free_idx;

   // Entry data path
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic [TIME_BITS-1:0]     elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [COUNT_BITS-1:0]    count_next;
   logic [TIME_BITS-1:0]     count_wide;
   logic [TIME_BITS-1:0]     count_next_wide;
   logic                     expired;

   // Response registers
   logic                     rsp_valid_ff;
   logic                     blocked_ff, blocked_in;
   logic                     exempt_hit_ff, exempt_hit_in;
   logic                     released_ff, released_in;
   logic [TIME_BITS-1:0]     remaining_ff, remaining_in;
   logic [OUT_CNT_BITS-1:0]  attempt_ff, attempt_in;
   logic                     full_ff, full_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_seconds_ff <= '0;
         attempt_limit_ff <= '0;
         exempt_addr_a_ff <= '0;
         exempt_addr_b_ff <= '0;
         exempt_enable_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BLOCK_SECONDS: block_seconds_ff <= csr_wdata[TIME_BITS-1:0];
            CSR_ATTEMPT_LIMIT: attempt_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            CSR_EXEMPT_ADDR_A: exempt_addr_a_ff <= csr_wdata[ADDR_BITS-1:0];
            CSR_EXEMPT_ADDR_B: exempt_addr_b_ff <= csr_wdata[ADDR_BITS-1:0];
            CSR_EXEMPT_ENABLE: exempt_enable_ff <= csr_wdata[EXEMPT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Parallel tag compare and exempt match
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (slot_addr_ff[i] == key_ff);
         free_in[i]  = !valid_ff[i];
      end
      exempt_in = (exempt_enable_ff[0] && (key_ff == exempt_addr_a_ff)) ||
                  (exempt_enable_ff[1] && (key_ff == exempt_addr_b_ff));
   end

   // Lowest-index hit and lowest-index free entry
   always_comb begin
      hit_in      = 1'b0;
      free_any_in = 1'b0;
      hit_idx     = '0;
      free_idx    = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_in  = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (free_ff[i]) begin
            free_any_in = 1'b1;
            free_idx    = IDX_W'(i);
         end
      end
      slot_in = hit_in ? hit_idx : free_idx;
   end

   // Elapsed time and starting count; a new entry starts from zero
   assign elapsed_in = now_ff - ram_rd_data[TIME_BITS-1:0];
   assign count_in   = hit_ff ? ram_rd_data[ENTRY_W-1:TIME_BITS] : '0;

   // Saturating increment and write-back data
   assign count_next  = (count_ff == {COUNT_BITS{1'b1}}) ? count_ff : count_ff + 1'b1;
   assign ram_wr_data = {count_next, now_ff};
   assign expired     = elapsed_ff > block_seconds_ff;
   assign count_wide      = TIME_BITS'(count_ff);
   assign count_next_wide = TIME_BITS'(count_next);

   // Response item
   always_comb begin
      blocked_in    = 1'b0;
      exempt_hit_in = cmd_ff && exempt_ff;
      released_in   = 1'b0;
      remaining_in  = '0;
      attempt_in    = '0;
      full_in       = cmd_ff && !exempt_ff && !hit_ff && !free_any_ff;
      if (cmd.record) begin
         attempt_in = (count_next_wide > TIME_BITS'({OUT_CNT_BITS{1'b1}})) ?
                      {OUT_CNT_BITS{1'b1}} : count_next_wide[OUT_CNT_BITS-1:0];
      end else if (cmd.check) begin
         if (expired) begin
            released_in = 1'b1;
         end else begin
            attempt_in = (count_wide > TIME_BITS'({OUT_CNT_BITS{1'b1}})) ?
                         {OUT_CNT_BITS{1'b1}} : count_wide[OUT_CNT_BITS-1:0];
            if (count_wide >= TIME_BITS'(attempt_limit_ff)) begin
               blocked_in   = 1'b1;
               remaining_in = block_seconds_ff - elapsed_ff;
            end
         end
      end
   end

   // Item capture and step registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         key_ff <= req_src_addr;
         now_ff <= req_now_seconds;
      end
      if (cmd.match) begin
         match_ff  <= match_in;
         free_ff   <= free_in;
         exempt_ff <= exempt_in;
      end
      if (cmd.select) begin
         hit_ff      <= hit_in;
         free_any_ff <= free_any_in;
         slot_ff     <= slot_in;
      end
      if (cmd.calc) begin
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
      end
      if (cmd.update) begin
         blocked_ff    <= blocked_in;
         exempt_hit_ff <= exempt_hit_in;
         released_ff   <= released_in;
         remaining_ff  <= remaining_in;
         attempt_ff    <= attempt_in;
         full_ff       <= full_in;
      end
   end

   // Valid bits: set on record, cleared on expiry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.record) begin
         valid_ff[slot_ff] <= 1'b1;
      end else if (cmd.check && expired) begin
         valid_ff[slot_ff] <= 1'b0;
      end
   end

   // Tags
   always_ff @(posedge clock) begin
      if (cmd.record) begin
         slot_addr_ff[slot_ff] <= key_ff;
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   // Count and stamp store
   fls_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.record),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.read),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign status.cmd_fail = cmd_ff;
   assign status.exempt   = exempt_ff;
   assign status.hit      = hit_ff;
   assign status.free_any = free_any_ff;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_blocked           = blocked_ff;
   assign rsp_exempt_hit        = exempt_hit_ff;
   assign rsp_released          = released_ff;
   assign rsp_remaining_seconds = remaining_ff;
   assign rsp_attempt_count     = attempt_ff;
   assign rsp_table_full        = full_ff;

   // An item ends in at most one of the outcomes
   `FLS_ASSERT_NOW(a_one_outcome, rsp_valid,
      $onehot0({rsp_blocked, rsp_exempt_hit, rsp_released, rsp_table_full}),
      "conflicting outcome flags")
   // A released or unrecorded item reports no count and no time
   `FLS_ASSERT_NOW(a_quiet_fields, rsp_valid && (rsp_released || rsp_exempt_hit || rsp_table_full),
      rsp_attempt_count == '0 && rsp_remaining_seconds == '0,
      "fields set on an item without a tracked entry")
   // A blocked source has been recorded at least once
   `FLS_ASSERT_NOW(a_blocked_count, rsp_valid && rsp_blocked, rsp_attempt_count != '0,
      "blocked source with zero attempts")
   // A recorded failure leaves its entry valid
   `FLS_ASSERT_NEXT(a_record_valid, cmd.record, valid_ff[slot_ff],
      "recorded entry not valid")

endmodule

>>> sim/tb_failed_login_source_blocklist.sv
// Self-checking testbench for the failed-login source blocklist: directed and random items.
// Depends on fls_pkg and failed_login_source_blocklist; results are predicted in-bench.
`timescale 1ns / 1ps

module tb_failed_login_source_blocklist;
   import fls_pkg::*;

   localparam int SLOTS       = 16;
   localparam int COUNT_BITS  = 16;
   localparam int BURST_ITEMS = 20;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 40;

   // Event codes on req_cmd
   localparam logic CMD_CHECK  = 1'b0;
   localparam logic CMD_RECORD = 1'b1;

   localparam logic [ADDR_BITS-1:0] EXEMPT_A   = 32'hC0A8_0001;
   localparam logic [ADDR_BITS-1:0] EXEMPT_B   = 32'h0A00_0002;
   localparam logic [ADDR_BITS-1:0] BURST_ADDR = 32'hC633_6401;

   typedef struct packed {
      logic                    blocked;
      logic                    exempt_hit;
      logic                    released;
      logic [TIME_BITS-1:0]    remaining_seconds;
      logic [OUT_CNT_BITS-1:0] attempt_count;
      logic                    table_full;
   } verdict_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = CMD_CHECK;
   logic [ADDR_BITS-1:0]      req_src_addr = '0;
   logic [TIME_BITS-1:0]      req_now_seconds = '0;
   logic                      rsp_valid;
   logic                      rsp_blocked;
   logic                      rsp_exempt_hit;
   logic                      rsp_released;
   logic [TIME_BITS-1:0]      rsp_remaining_seconds;
   logic [OUT_CNT_BITS-1:0]   rsp_attempt_count;
   logic                      rsp_table_full;

   failed_login_source_blocklist #(
      .TABLE_ENTRIES(SLOTS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_src_addr         (req_src_addr),
      .req_now_seconds      (req_now_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_blocked          (rsp_blocked),
      .rsp_exempt_hit       (rsp_exempt_hit),
      .rsp_released         (rsp_released),
      .rsp_remaining_seconds(rsp_remaining_seconds),
      .rsp_attempt_count    (rsp_attempt_count),
      .rsp_table_full       (rsp_table_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted configuration and tracking table
   logic [TIME_BITS-1:0]  cfg_block_secs    = '0;
   logic [LIMIT_BITS-1:0] cfg_attempt_limit = '0;
   logic [ADDR_BITS-1:0]  cfg_exempt_a      = '0;
   logic [ADDR_BITS-1:0]  cfg_exempt_b      = '0;
   logic [EXEMPT_BITS-1:0] cfg_exempt_en    = '0;
   bit                    tr_valid [SLOTS];
   logic [ADDR_BITS-1:0]  tr_addr  [SLOTS];
   logic [COUNT_BITS-1:0] tr_count [SLOTS];
   logic [TIME_BITS-1:0]  tr_stamp [SLOTS];

   verdict_type pending_verdicts [$];
   verdict_type seen_verdict;
   verdict_type want_verdict;
   bit       no_gaps = 1'b0;
   int       n_items, n_results, n_blocked, n_released, n_exempt, n_full;
   int       mismatches;
   int       idle_cycles;

   // Count as shown on the 16-bit output, clamped for wider counters
   function automatic logic [OUT_CNT_BITS-1:0] count_field(input logic [COUNT_BITS-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return (wide > 32'hFFFF) ? 16'hFFFF : wide[OUT_CNT_BITS-1:0];
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_BLOCK_SECONDS: cfg_block_secs    = data[TIME_BITS-1:0];
         CSR_ATTEMPT_LIMIT: cfg_attempt_limit = data[LIMIT_BITS-1:0];
         CSR_EXEMPT_ADDR_A: cfg_exempt_a      = data[ADDR_BITS-1:0];
         CSR_EXEMPT_ADDR_B: cfg_exempt_b      = data[ADDR_BITS-1:0];
         CSR_EXEMPT_ENABLE: cfg_exempt_en     = data[EXEMPT_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Blocklist decision for one event; updates the tracking table
   function automatic verdict_type blocklist_predict(input logic cmd,
                                                     input logic [ADDR_BITS-1:0] addr,
                                                     input logic [TIME_BITS-1:0] now);
      verdict_type v;
      int hit;
      int free;
      logic [TIME_BITS-1:0] elapsed;
      v = '0;
      hit = -1;
      free = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (tr_valid[i] && tr_addr[i] == addr && hit < 0) hit = i;
         if (!tr_valid[i] && free < 0) free = i;
      end
      if (cmd == CMD_RECORD) begin
         if ((cfg_exempt_en[0] && addr == cfg_exempt_a) ||
             (cfg_exempt_en[1] && addr == cfg_exempt_b)) begin
            v.exempt_hit = 1'b1;
         end else begin
            // allocate the lowest free slot for a new source
            if (hit < 0 && free >= 0) begin
               hit = free;
               tr_valid[hit] = 1'b1;
               tr_addr[hit] = addr;
               tr_count[hit] = '0;
            end
            if (hit < 0) begin
               v.table_full = 1'b1;
            end else begin
               if (tr_count[hit] != {COUNT_BITS{1'b1}}) tr_count[hit]++;
               tr_stamp[hit] = now;
               v.attempt_count = count_field(tr_count[hit]);
            end
         end
      end else if (hit >= 0) begin
         elapsed = now - tr_stamp[hit];
         if (elapsed > cfg_block_secs) begin
            tr_valid[hit] = 1'b0;
            v.released = 1'b1;
         end else begin
            v.attempt_count = count_field(tr_count[hit]);
            if (tr_count[hit] >= cfg_attempt_limit) begin
               v.blocked = 1'b1;
               v.remaining_seconds = cfg_block_secs - elapsed;
            end
         end
      end
      return v;
   endfunction

   function automatic string verdict_text(input verdict_type v);
      return $sformatf("blocked=%0b exempt_hit=%0b released=%0b remaining=%0d count=%0d full=%0b",
                       v.blocked, v.exempt_hit, v.released, v.remaining_seconds,
                       v.attempt_count, v.table_full);
   endfunction

   // Result checker: every strobed result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_verdict = {rsp_blocked, rsp_exempt_hit, rsp_released, rsp_remaining_seconds,
                         rsp_attempt_count, rsp_table_full};
         n_results++;
         n_blocked  += seen_verdict.blocked;
         n_released += seen_verdict.released;
         n_exempt   += seen_verdict.exempt_hit;
         n_full     += seen_verdict.table_full;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with nothing pending: %s", n_results,
                        verdict_text(seen_verdict));
         end else begin
            want_verdict = pending_verdicts.pop_front();
            if (seen_verdict !== want_verdict) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d mismatch, expected %s", n_results,
                           verdict_text(want_verdict));
                  $display("result %0d mismatch, actual   %s", n_results,
                           verdict_text(seen_verdict));
               end
            end
         end
      end
   end

   // Watchdog on cycles where no item, result or register write moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no activity for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one item, predict it once the block drops busy, then draw the gap before the next one
   task automatic send_event(input logic cmd, input logic [ADDR_BITS-1:0] addr,
                             input logic [TIME_BITS-1:0] now);
      int gap;
      start <= 1'b1;
      req_cmd <= cmd;
      req_src_addr <= addr;
      req_now_seconds <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_verdicts.push_back(blocklist_predict(cmd, addr, now));
      n_items++;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
   endtask

   // Write every register; unused high bits and a spare index carry random junk
   task automatic program_regs(input logic [TIME_BITS-1:0] secs,
                               input logic [LIMIT_BITS-1:0] limit,
                               input logic [ADDR_BITS-1:0] ea,
                               input logic [ADDR_BITS-1:0] eb,
                               input logic [EXEMPT_BITS-1:0] en);
      logic [31:0] junk;
      logic [CSR_INDEX_BITS-1:0] spare;
      junk = $urandom;
      spare = CSR_INDEX_BITS'($urandom_range(CSR_EXEMPT_ENABLE + 1, 2**CSR_INDEX_BITS - 1));
      write_reg(spare, $urandom);
      write_reg(CSR_BLOCK_SECONDS, secs);
      write_reg(CSR_ATTEMPT_LIMIT, {junk[31:16], limit});
      write_reg(CSR_EXEMPT_ADDR_A, ea);
      write_reg(CSR_EXEMPT_ADDR_B, eb);
      write_reg(CSR_EXEMPT_ENABLE, {junk[29:0], en});
      csr_write_en <= 1'b0;
   endtask

   // Expire every tracked source: zero window, then check each one second later
   task automatic release_all();
      wait_idle();
      program_regs('0, cfg_attempt_limit, cfg_exempt_a, cfg_exempt_b, cfg_exempt_en);
      for (int i = 0; i < SLOTS; i++)
         if (tr_valid[i]) send_event(CMD_CHECK, tr_addr[i], tr_stamp[i] + 1);
      wait_idle();
   endtask

   // Unknown source, counting below the limit, blocking, window edge and release
   task automatic test_lookup_and_block();
      program_regs(100, 16'd3, EXEMPT_A, EXEMPT_B, 2'b00);
      send_event(CMD_CHECK,  32'h0A0B_0C0D, 500);
      send_event(CMD_RECORD, 32'h0A0B_0C0D, 1000);
      send_event(CMD_CHECK,  32'h0A0B_0C0D, 1000);
      send_event(CMD_RECORD, 32'h0A0B_0C0D, 1010);
      send_event(CMD_RECORD, 32'h0A0B_0C0D, 1020);
      send_event(CMD_CHECK,  32'h0A0B_0C0D, 1070);
      send_event(CMD_CHECK,  32'h0A0B_0C0D, 1120);
      send_event(CMD_CHECK,  32'h0A0B_0C0D, 1121);
      send_event(CMD_CHECK,  32'h0A0B_0C0D, 1122);
      wait_idle();
   endtask

   // Each exempt enable bit alone and together; checks ignore exemption
   task automatic test_exempt_addresses();
      program_regs(100, 16'd1, EXEMPT_A, EXEMPT_B, 2'b01);
      send_event(CMD_RECORD, EXEMPT_A, 2000);
      send_event(CMD_RECORD, EXEMPT_B, 2000);
      wait_idle();
      program_regs(100, 16'd1, EXEMPT_A, EXEMPT_B, 2'b10);
      send_event(CMD_RECORD, EXEMPT_B, 2001);
      send_event(CMD_RECORD, EXEMPT_A, 2001);
      send_event(CMD_CHECK,  EXEMPT_B, 2002);
      wait_idle();
      program_regs(100, 16'd1, EXEMPT_A, EXEMPT_B, 2'b11);
      send_event(CMD_RECORD, EXEMPT_A, 2003);
      send_event(CMD_RECORD, EXEMPT_B, 2003);
      wait_idle();
   endtask

   // Zero and full-range windows, zero limit, time wraparound, extreme addresses
   task automatic test_window_extremes();
      release_all();
      program_regs('0, '0, EXEMPT_A, EXEMPT_B, 2'b00);
      send_event(CMD_RECORD, 32'h0000_0000, 32'hFFFF_FFFF);
      send_event(CMD_CHECK,  32'h0000_0000, 32'hFFFF_FFFF);
      send_event(CMD_CHECK,  32'h0000_0000, 32'h0000_0000);
      wait_idle();
      program_regs('1, '1, EXEMPT_A, EXEMPT_B, 2'b00);
      send_event(CMD_RECORD, 32'hFFFF_FFFF, 32'h0000_0010);
      send_event(CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_000F);
      wait_idle();
      program_regs('1, 16'd1, EXEMPT_A, EXEMPT_B, 2'b00);
      send_event(CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_000F);
      send_event(CMD_CHECK,  32'hFFFF_FFFF, 32'h0000_0010);
      wait_idle();
      program_regs(100, 16'd2, EXEMPT_A, EXEMPT_B, 2'b00);
      send_event(CMD_RECORD, 32'h8000_0000, 32'hFFFF_FFF0);
      send_event(CMD_RECORD, 32'h8000_0000, 32'hFFFF_FFF8);
      send_event(CMD_CHECK,  32'h8000_0000, 32'h0000_0020);
      wait_idle();
   endtask

   // Fill every slot, overflow, then reuse a freed slot
   task automatic test_table_capacity();
      release_all();
      program_regs(1000, 16'd2, EXEMPT_A, EXEMPT_B, 2'b00);
      for (int i = 0; i < SLOTS; i++) send_event(CMD_RECORD, 32'h0A00_0100 + i, 3000 + i);
      send_event(CMD_RECORD, 32'h0A00_0200, 3020);
      send_event(CMD_RECORD, 32'h0A00_0105, 3021);
      send_event(CMD_CHECK,  32'h0A00_0200, 3022);
      send_event(CMD_CHECK,  32'h0A00_0103, 5000);
      send_event(CMD_RECORD, 32'h0A00_0200, 5001);
      send_event(CMD_RECORD, 32'h0A00_0201, 5002);
      wait_idle();
   endtask

   // Run one source through a burst of failures, back to back
   task automatic test_count_burst();
      release_all();
      program_regs('1, '1, EXEMPT_A, EXEMPT_B, 2'b00);
      no_gaps = 1'b1;
      for (int i = 1; i <= BURST_ITEMS; i++) send_event(CMD_RECORD, BURST_ADDR, i);
      send_event(CMD_CHECK,  BURST_ADDR, BURST_ITEMS + 1);
      send_event(CMD_RECORD, BURST_ADDR, BURST_ITEMS + 1);
      send_event(CMD_RECORD, BURST_ADDR, BURST_ITEMS + 2);
      send_event(CMD_CHECK,  BURST_ADDR, BURST_ITEMS + 3);
      no_gaps = 1'b0;
      wait_idle();
   endtask

   // Random events over a small address pool so sources repeat, expire and fill the table
   task automatic test_random_traffic();
      logic [ADDR_BITS-1:0] pool [POOL_SIZE];
      logic [TIME_BITS-1:0] clk_secs;
      logic [TIME_BITS-1:0] now;
      logic [ADDR_BITS-1:0] addr;
      logic                 cmd;
      int                   pick;
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
      pool[0] = '0;
      pool[1] = '1;
      clk_secs = $urandom;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 3 || $urandom_range(0, 1)) release_all();
         else wait_idle();
         case (phase)
            0: program_regs('0, '0, pool[2], pool[3], 2'b11);
            1: program_regs('1, '1, pool[4], $urandom, 2'b01);
            2: program_regs('1, 16'd1, $urandom, pool[5], 2'b10);
            default: program_regs($urandom_range(0, 40), LIMIT_BITS'($urandom_range(0, 6)),
                                  pool[$urandom_range(0, POOL_SIZE - 1)],
                                  pool[$urandom_range(0, POOL_SIZE - 1)],
                                  EXEMPT_BITS'($urandom_range(0, 3)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
            cmd = ($urandom_range(0, 99) < 55) ? CMD_RECORD : CMD_CHECK;
            addr = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               clk_secs = $urandom;
               now = clk_secs;
            end else if (pick == 1) begin
               // a timestamp in the past looks like a very long elapsed time
               now = clk_secs - $urandom_range(1, 50);
            end else begin
               clk_secs = clk_secs + $urandom_range(0, 4);
               now = clk_secs;
            end
            send_event(cmd, addr, now);
         end
         no_gaps = 1'b0;
      end
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_lookup_and_block();
      test_exempt_addresses();
      test_window_extremes();
      test_table_capacity();
      test_count_burst();
      test_random_traffic();
      wait_idle();
      $display("Ran %0d items: lookup, exempt, window edge, capacity, failure burst and random.",
               n_items);
      $display("Checked %0d results (%0d blocked, %0d released, %0d exempt, %0d full), %0d bad.",
               n_results, n_blocked, n_released, n_exempt, n_full, mismatches);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
